[rtl/lfs_pkg.sv]
package lfs_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned SEEN_W      = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Length field sizes of the two framing versions.
  localparam logic [SEEN_W-1:0] FIELD_LEN_OLD = SEEN_W'(4);
  localparam logic [SEEN_W-1:0] FIELD_LEN_NEW = SEEN_W'(3);
  localparam logic [LEN_W-1:0]  OLD_HDR_BYTES = LEN_W'(4);

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION_MODE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH   = CFG_INDEX_W'(1);

  localparam logic       VERSION_RESET = 1'b1;
  localparam logic [7:0] MIN_LEN_RESET = 8'd6;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  // One result word as it travels through the queue.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              empty_frame;
    logic              stream_error;
  } result_t;

  // Configuration write as seen by the front end.
  typedef struct packed {
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;
  } cfg_wr_t;

endpackage

[rtl/lfs_front.sv]
module lfs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  lfs_pkg::cfg_wr_t         cfg_wr,
  input  logic                     in_accept,
  input  logic [lfs_pkg::BYTE_W-1:0] in_byte,
  output logic                     push,
  output lfs_pkg::result_t         push_word
);
  import lfs_pkg::*;

  logic              version_mode;
  logic [7:0]        min_frame_length;
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  length_accumulator, length_accumulator_next;
  logic [SEEN_W-1:0] length_bytes_seen, length_bytes_seen_next;
  logic [LEN_W-1:0]  payload_remaining, payload_remaining_next;
  logic              at_frame_start, at_frame_start_next;

  logic [SEEN_W-1:0] field_len;
  logic [SEEN_W-1:0] seen_inc;
  logic [LEN_W-1:0]  acc_shift;
  logic              field_done;
  logic              len_small;
  logic [LEN_W-1:0]  len_old;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  rem_dec;
  logic              rem_last;

  assign field_len  = version_mode ? FIELD_LEN_NEW : FIELD_LEN_OLD;
  assign seen_inc   = length_bytes_seen + SEEN_W'(1);
  assign acc_shift  = {length_accumulator[LEN_W-BYTE_W-1:0], in_byte};
  assign field_done = (seen_inc >= field_len);
  assign len_small  = (acc_shift < {{(LEN_W-8){1'b0}}, min_frame_length});
  assign len_old    = (acc_shift >= OLD_HDR_BYTES) ? (acc_shift - OLD_HDR_BYTES) : '0;
  assign len_eff    = version_mode ? acc_shift : len_old;
  assign rem_dec    = payload_remaining - LEN_W'(1);
  assign rem_last   = (rem_dec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      version_mode     <= VERSION_RESET;
      min_frame_length <= MIN_LEN_RESET;
    end else if (cfg_wr.wr_en) begin
      if (cfg_wr.index == CFG_VERSION_MODE) begin
        version_mode <= cfg_wr.data[0];
      end else if (cfg_wr.index == CFG_MIN_LENGTH) begin
        min_frame_length <= cfg_wr.data;
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_accept) begin
      unique case (phase)
        PH_LENGTH: begin
          if (field_done) begin
            if (len_small) begin
              phase_next = PH_ERROR;
            end else if (len_eff != '0) begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (rem_last) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_ERROR: phase_next = PH_ERROR;
        default:  phase_next = PH_ERROR;
      endcase
    end
  end

  // Datapath updates and result word.
  always_comb begin
    length_accumulator_next = length_accumulator;
    length_bytes_seen_next  = length_bytes_seen;
    payload_remaining_next  = payload_remaining;
    at_frame_start_next     = at_frame_start;
    push                    = 1'b0;
    push_word               = '0;
    if (in_accept) begin
      unique case (phase)
        PH_LENGTH: begin
          if (field_done) begin
            length_accumulator_next = '0;
            length_bytes_seen_next  = '0;
            if (len_small) begin
              push                   = 1'b1;
              push_word.stream_error = 1'b1;
            end else if (len_eff == '0) begin
              at_frame_start_next     = 1'b1;
              push                    = 1'b1;
              push_word.last_of_frame = 1'b1;
              push_word.empty_frame   = 1'b1;
            end else begin
              payload_remaining_next = len_eff;
              at_frame_start_next    = 1'b1;
            end
          end else begin
            length_accumulator_next = acc_shift;
            length_bytes_seen_next  = seen_inc;
          end
        end
        PH_PAYLOAD: begin
          payload_remaining_next   = rem_dec;
          at_frame_start_next      = rem_last;
          push                     = 1'b1;
          push_word.payload_byte   = in_byte;
          push_word.first_of_frame = at_frame_start;
          push_word.last_of_frame  = rem_last;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LENGTH;
      length_accumulator <= '0;
      length_bytes_seen  <= '0;
      payload_remaining  <= '0;
      at_frame_start     <= 1'b1;
    end else begin
      phase              <= phase_next;
      length_accumulator <= length_accumulator_next;
      length_bytes_seen  <= length_bytes_seen_next;
      payload_remaining  <= payload_remaining_next;
      at_frame_start     <= at_frame_start_next;
    end
  end

  // A field completes on the byte that reaches its size, so the stored count stays at most three.
  assert property (@(posedge clk) disable iff (rst) length_bytes_seen <= FIELD_LEN_NEW)
    else $error("length byte count ran past the longest partial field");

  // Once the stream is in error nothing more is produced.
  assert property (@(posedge clk) disable iff (rst) (phase == PH_ERROR) |-> !push)
    else $error("word produced after stream error");

  // An error word always locks the parser.
  assert property (@(posedge clk) disable iff (rst)
    (push && push_word.stream_error) |=> (phase == PH_ERROR))
    else $error("error word without entering error phase");

endmodule

[rtl/lfs_queue.sv]
module lfs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lfs_pkg::result_t push_word,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output lfs_pkg::result_t out_word
);
  import lfs_pkg::*;

  result_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("write into a full queue");

  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count missed a write");

endmodule

[rtl/length_prefixed_frame_splitter_top.sv]
// Length-prefixed frame splitter.
//
// Bytes of a raw stream enter on the s_axis channel, one word per byte. Each
// frame opens with a big-endian length field: four bytes counting themselves
// when version_mode is 0, three bytes counting only the payload when it is 1.
// Every payload byte leaves on the m_axis channel with first and last marks in
// tuser and tlast. A frame with no payload gives one empty-frame word, and a
// length below min_frame_length gives one error word after which all further
// input is swallowed until reset. Length bytes produce no payload word.
// Registers are written on the cfg channel (index 0 version_mode, index 1
// min_frame_length); other indexes are ignored. Write them only while idle.
// A payload byte accepted at an edge enters the queue at that edge and is
// on m_axis right after it if no earlier word waits. Throughput is one byte
// per clock while the queue is not full. A four-word queue sits between
// parser and output, so input keeps flowing while a result waits; when the
// receiver stalls the queue fills; s_axis_tready drops only once it is full.
// Reset (rst, synchronous) empties the queue, restores register defaults and
// clears any error lock, returning the parser to length collection.
module length_prefixed_frame_splitter_top (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lfs_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  // Output stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lfs_pkg::BYTE_W-1:0]  m_axis_tdata,  // [7:0] payload_byte
  output logic                        m_axis_tlast,  // last_of_frame
  output logic [2:0]                  m_axis_tuser,  // [0] first_of_frame,
                                                     // [1] empty_frame, [2] stream_error
  // Configuration writes.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfs_pkg::BYTE_W-1:0]  cfg_data
);
  import lfs_pkg::*;

  cfg_wr_t cfg_wr;
  logic    in_accept;
  logic    push;
  result_t push_word;
  logic    queue_full;
  result_t out_word;

  // Register writes are always taken.
  assign cfg_ready     = 1'b1;
  assign cfg_wr.wr_en  = cfg_valid;
  assign cfg_wr.index  = cfg_index;
  assign cfg_wr.data   = cfg_data;

  // Keep accepting as long as the queue can take one more word.
  assign s_axis_tready = !queue_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_accept (in_accept),
    .in_byte   (s_axis_tdata),
    .push      (push),
    .push_word (push_word)
  );

  lfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = out_word.payload_byte;
  assign m_axis_tlast = out_word.last_of_frame;
  assign m_axis_tuser = {out_word.stream_error, out_word.empty_frame, out_word.first_of_frame};

endmodule
